// ===== design/ipv4_header_check_and_forward_assert.svh =====
// Assertion macros shared by the IPv4 header checker modules.
// Define ASSERT_OFF to compile them away.
`ifndef IPV4_HEADER_CHECK_AND_FORWARD_ASSERT_SVH
`define IPV4_HEADER_CHECK_AND_FORWARD_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");
// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");
// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/ihcf_pkg.sv =====
`timescale 1ns / 1ps
package ihcf_pkg;

   // Byte counter saturates here, so an oversize packet never matches its length
   localparam logic [16:0] COUNT_MAX = 17'h1ffff;

   // Byte offsets of header fields
   localparam logic [16:0] OFF_VER_LEN   = 17'd0;
   localparam logic [16:0] OFF_TOTAL_HI  = 17'd2;
   localparam logic [16:0] OFF_TOTAL_LO  = 17'd3;
   localparam logic [16:0] OFF_FRAG_HI   = 17'd6;
   localparam logic [16:0] OFF_FRAG_LO   = 17'd7;
   localparam logic [16:0] OFF_TTL       = 17'd8;
   localparam logic [16:0] OFF_PROTO     = 17'd9;
   localparam logic [16:0] OFF_CSUM_HI   = 17'd10;
   localparam logic [16:0] OFF_CSUM_LO   = 17'd11;
   localparam logic [16:0] OFF_SRC       = 17'd12;
   localparam logic [16:0] OFF_DST       = 17'd16;
   localparam logic [16:0] OFF_OPTIONS   = 17'd20;

   localparam logic [3:0]  IP_VERSION4   = 4'd4;
   localparam logic [5:0]  MIN_HDR_LEN   = 6'd20;
   localparam logic [6:0]  QUOTE_EXTRA   = 7'd8;
   localparam logic [7:0]  PROTO_ICMP    = 8'd1;
   localparam logic [15:0] ICMP_ECHO_REQ = 16'h0800;
   localparam logic [7:0]  ICMP_UNREACH  = 8'd3;
   localparam logic [7:0]  ICMP_TIME_EXC = 8'd11;
   localparam logic [7:0]  ICMP_PARAM    = 8'd12;
   localparam logic [15:0] FRAG_ANY_MASK = 16'hbfff;
   localparam logic [15:0] FRAG_OFF_MASK = 16'h1fff;
   localparam logic [7:0]  LOOPBACK_NET  = 8'h7f;
   localparam logic [3:0]  MCAST_NET     = 4'he;
   localparam logic [3:0]  RESERVED_NET  = 4'hf;
   localparam logic [7:0]  TTL_MAX       = 8'd255;
   localparam logic [15:0] CSUM_GOOD     = 16'hffff;

   // Configuration register indexes
   localparam logic CSR_OWN_ADDRESS    = 1'b0;
   localparam logic CSR_POINT_TO_POINT = 1'b1;

   typedef enum logic [2:0] {
      ACT_MALFORMED     = 3'd0,
      ACT_PTP_HOST      = 3'd1,
      ACT_PTP_TUNNEL    = 3'd2,
      ACT_FORWARD       = 3'd3,
      ACT_TIME_EXCEEDED = 3'd4,
      ACT_ECHO_REPLY    = 3'd5,
      ACT_PROTO_UNREACH = 3'd6,
      ACT_SILENT_DROP   = 3'd7
   } action_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       from_tunnel;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  new_ttl;
      logic [15:0] new_header_checksum;
      logic [6:0]  reply_length;
      logic [31:0] reply_target;
   } rsp_type;

   // Captured header of one complete packet, handed from front to back
   typedef struct packed {
      logic [16:0] byte_count;
      logic [20:0] sum_other_words;
      logic [15:0] stored_checksum;
      logic [7:0]  version_and_length;
      logic [15:0] total_length;
      logic [15:0] fragment_word;
      logic [7:0]  ttl_value;
      logic [7:0]  protocol_value;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [15:0] icmp_type_code;
      logic        came_from_tunnel;
   } pkt_type;

   // Ones'-complement fold of a 22-bit sum; two folds always suffice
   function automatic logic [15:0] fold16(input logic [21:0] s);
      logic [16:0] f;
      f = {1'b0, s[15:0]} + {11'd0, s[21:16]};
      return f[15:0] + {15'd0, f[16]};
   endfunction

endpackage

// ===== design/ihcf_front.sv =====
`timescale 1ns / 1ps
module ihcf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ihcf_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output ihcf_pkg::pkt_type q_data
);

   ihcf_pkg::pkt_type pkt_ff, pkt_in;
   logic              accept;
   logic [16:0]       off;
   logic [5:0]        hlen_cur;
   logic [16:0]       hlen_ext;
   logic [7:0]        b;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign off       = pkt_ff.byte_count;
   assign b         = req_data.data_byte;

   // header length: the first byte supplies it directly
   assign hlen_cur = (off == ihcf_pkg::OFF_VER_LEN) ? {b[3:0], 2'b00}
                                                     : {pkt_ff.version_and_length[3:0], 2'b00};
   assign hlen_ext = {11'd0, hlen_cur};

   // field capture and running sum for the byte being taken
   always_comb begin
      pkt_in = pkt_ff;
      if (off == ihcf_pkg::OFF_VER_LEN) begin
         pkt_in.version_and_length = b;
         pkt_in.came_from_tunnel   = req_data.from_tunnel;
      end
      if (off == ihcf_pkg::OFF_TOTAL_HI || off == ihcf_pkg::OFF_TOTAL_LO) begin
         pkt_in.total_length = {pkt_ff.total_length[7:0], b};
      end
      if (off == ihcf_pkg::OFF_FRAG_HI || off == ihcf_pkg::OFF_FRAG_LO) begin
         pkt_in.fragment_word = {pkt_ff.fragment_word[7:0], b};
      end
      if (off == ihcf_pkg::OFF_TTL) begin
         pkt_in.ttl_value = b;
      end
      if (off == ihcf_pkg::OFF_PROTO) begin
         pkt_in.protocol_value = b;
      end
      if (off == ihcf_pkg::OFF_CSUM_HI || off == ihcf_pkg::OFF_CSUM_LO) begin
         pkt_in.stored_checksum = {pkt_ff.stored_checksum[7:0], b};
      end
      if (off >= ihcf_pkg::OFF_SRC && off < ihcf_pkg::OFF_DST) begin
         pkt_in.source_addr = {pkt_ff.source_addr[23:0], b};
      end
      if (off >= ihcf_pkg::OFF_DST && off < ihcf_pkg::OFF_OPTIONS) begin
         pkt_in.dest_addr = {pkt_ff.dest_addr[23:0], b};
      end
      // words other than TTL/protocol, checksum and addresses
      if (off < ihcf_pkg::OFF_TTL || (off >= ihcf_pkg::OFF_OPTIONS && off < hlen_ext)) begin
         if (off[0]) begin
            pkt_in.sum_other_words = pkt_ff.sum_other_words + {13'd0, b};
         end else begin
            pkt_in.sum_other_words = pkt_ff.sum_other_words + {5'd0, b, 8'h00};
         end
      end
      // ICMP type and code: the two bytes right after the header
      if (off >= ihcf_pkg::OFF_OPTIONS && (off == hlen_ext || off == hlen_ext + 17'd1)) begin
         pkt_in.icmp_type_code = {pkt_ff.icmp_type_code[7:0], b};
      end
      if (pkt_ff.byte_count != ihcf_pkg::COUNT_MAX) begin
         pkt_in.byte_count = pkt_ff.byte_count + 17'd1;
      end
   end

   assign q_push = accept && req_data.last_byte;
   assign q_data = pkt_in;

   // per-packet state, cleared after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff <= '0;
      end else if (accept) begin
         if (req_data.last_byte) begin
            pkt_ff <= '0;
         end else begin
            pkt_ff <= pkt_in;
         end
      end
   end

endmodule

// ===== design/ihcf_queue.sv =====
`timescale 1ns / 1ps
`include "ipv4_header_check_and_forward_assert.svh"
module ihcf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ihcf_pkg::pkt_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output ihcf_pkg::pkt_type head_data
);

   localparam logic [1:0] DEPTH = 2'd2;

   ihcf_pkg::pkt_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full       = (count_ff == DEPTH);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH)
   `ASSERT_IMPLY(a_no_push_full, clock, reset, push, count_ff != DEPTH)
   `ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, count_ff != 2'd0)
   `ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == 2'($past(count_ff) + 2'd1))

endmodule

// ===== design/ihcf_back.sv =====
`timescale 1ns / 1ps
`include "ipv4_header_check_and_forward_assert.svh"
module ihcf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  ihcf_pkg::pkt_type q_data,
   output logic              q_pop,
   input  logic [31:0]       own_address,
   input  logic              point_to_point,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ihcf_pkg::rsp_type rsp_data
);

   // stage 1: checks and partial sums
   typedef struct packed {
      logic        bad_len;
      logic [21:0] base_sum;
      logic [16:0] dst_sum;
      logic [15:0] stored_checksum;
      logic [7:0]  ttl_value;
      logic        is_icmp;
      logic        is_echo;
      logic        frag_any;
      logic        no_reply;
      logic        dst_local;
      logic        tunnel;
      logic [6:0]  quote_len;
      logic [31:0] source_addr;
   } s1_type;

   // stage 2: full sums ready for folding
   typedef struct packed {
      logic        bad_len;
      logic [21:0] check_sum;
      logic [21:0] fwd_sum;
      logic [21:0] echo_sum;
      logic [7:0]  next_ttl;
      logic        ttl_expired;
      logic        is_icmp;
      logic        is_echo;
      logic        frag_any;
      logic        no_reply;
      logic        dst_local;
      logic        tunnel;
      logic [6:0]  quote_len;
      logic [31:0] source_addr;
   } s2_type;

   s1_type            s1_ff, s1_in;
   s2_type            s2_ff, s2_in;
   logic              s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   ihcf_pkg::rsp_type rsp_ff, rsp_in;
   logic              advance;
   logic [5:0]        hlen;
   logic [6:0]        hlen_quote;
   logic [7:0]        icmp_type;
   logic              src_bad;
   logic              err_icmp;

   // whole pipe moves when the output register can take a new result
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign q_pop     = advance && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // stage 1 logic
   assign hlen       = {q_data.version_and_length[3:0], 2'b00};
   assign hlen_quote = {1'b0, hlen} + ihcf_pkg::QUOTE_EXTRA;
   assign icmp_type  = q_data.icmp_type_code[15:8];
   assign src_bad    = (q_data.source_addr == 32'd0)
                    || (q_data.source_addr[31:24] == ihcf_pkg::LOOPBACK_NET)
                    || (q_data.source_addr[31:28] == ihcf_pkg::MCAST_NET)
                    || (q_data.source_addr[31:28] == ihcf_pkg::RESERVED_NET);
   assign err_icmp   = (q_data.protocol_value == ihcf_pkg::PROTO_ICMP)
                    && (icmp_type == ihcf_pkg::ICMP_UNREACH
                     || icmp_type == ihcf_pkg::ICMP_TIME_EXC
                     || icmp_type == ihcf_pkg::ICMP_PARAM);

   always_comb begin
      s1_in.bad_len = (q_data.version_and_length[7:4] != ihcf_pkg::IP_VERSION4)
                   || (hlen < ihcf_pkg::MIN_HDR_LEN)
                   || (q_data.byte_count < {11'd0, hlen})
                   || (q_data.byte_count != {1'b0, q_data.total_length})
                   || (q_data.total_length < {10'd0, hlen});
      s1_in.base_sum = {1'b0, q_data.sum_other_words}
                     + {6'd0, q_data.source_addr[31:16]}
                     + {6'd0, q_data.source_addr[15:0]}
                     + {14'd0, q_data.protocol_value};
      s1_in.dst_sum  = {1'b0, q_data.dest_addr[31:16]} + {1'b0, q_data.dest_addr[15:0]};
      s1_in.stored_checksum = q_data.stored_checksum;
      s1_in.ttl_value   = q_data.ttl_value;
      s1_in.is_icmp     = (q_data.protocol_value == ihcf_pkg::PROTO_ICMP);
      s1_in.is_echo     = (q_data.icmp_type_code == ihcf_pkg::ICMP_ECHO_REQ);
      s1_in.frag_any    = (q_data.fragment_word & ihcf_pkg::FRAG_ANY_MASK) != 16'd0;
      s1_in.no_reply    = err_icmp || src_bad
                       || ((q_data.fragment_word & ihcf_pkg::FRAG_OFF_MASK) != 16'd0);
      s1_in.dst_local   = (q_data.dest_addr == own_address);
      s1_in.tunnel      = q_data.came_from_tunnel;
      s1_in.quote_len   = (q_data.total_length < {9'd0, hlen_quote})
                        ? q_data.total_length[6:0] : hlen_quote;
      s1_in.source_addr = q_data.source_addr;
   end

   // stage 2 logic: the three header sums
   always_comb begin
      s2_in.bad_len     = s1_ff.bad_len;
      s2_in.next_ttl    = s1_ff.ttl_value - 8'd1;
      s2_in.check_sum   = s1_ff.base_sum + {6'd0, s1_ff.ttl_value, 8'h00}
                        + {6'd0, s1_ff.stored_checksum} + {5'd0, s1_ff.dst_sum};
      s2_in.fwd_sum     = s1_ff.base_sum + {6'd0, s2_in.next_ttl, 8'h00}
                        + {5'd0, s1_ff.dst_sum};
      s2_in.echo_sum    = s1_ff.base_sum + {6'd0, ihcf_pkg::TTL_MAX, 8'h00}
                        + {6'd0, own_address[31:16]} + {6'd0, own_address[15:0]};
      s2_in.ttl_expired = (s1_ff.ttl_value <= 8'd1);
      s2_in.is_icmp     = s1_ff.is_icmp;
      s2_in.is_echo     = s1_ff.is_echo;
      s2_in.frag_any    = s1_ff.frag_any;
      s2_in.no_reply    = s1_ff.no_reply;
      s2_in.dst_local   = s1_ff.dst_local;
      s2_in.tunnel      = s1_ff.tunnel;
      s2_in.quote_len   = s1_ff.quote_len;
      s2_in.source_addr = s1_ff.source_addr;
   end

   // stage 3 logic: verdict
   always_comb begin
      rsp_in = '0;
      rsp_in.action = ihcf_pkg::ACT_MALFORMED;
      if (!s2_ff.bad_len && ihcf_pkg::fold16(s2_ff.check_sum) == ihcf_pkg::CSUM_GOOD) begin
         rsp_in.reply_target = s2_ff.source_addr;
         if (point_to_point) begin
            rsp_in.action = s2_ff.tunnel ? ihcf_pkg::ACT_PTP_HOST : ihcf_pkg::ACT_PTP_TUNNEL;
         end else if (s2_ff.dst_local) begin
            if (s2_ff.frag_any) begin
               rsp_in.action = ihcf_pkg::ACT_SILENT_DROP;
            end else if (s2_ff.is_icmp) begin
               if (s2_ff.is_echo) begin
                  rsp_in.action = ihcf_pkg::ACT_ECHO_REPLY;
                  rsp_in.new_ttl = ihcf_pkg::TTL_MAX;
                  rsp_in.new_header_checksum = ~ihcf_pkg::fold16(s2_ff.echo_sum);
               end else begin
                  rsp_in.action = ihcf_pkg::ACT_SILENT_DROP;
               end
            end else if (!s2_ff.no_reply) begin
               rsp_in.action = ihcf_pkg::ACT_PROTO_UNREACH;
               rsp_in.reply_length = s2_ff.quote_len;
            end else begin
               rsp_in.action = ihcf_pkg::ACT_SILENT_DROP;
            end
         end else if (s2_ff.ttl_expired) begin
            if (!s2_ff.no_reply) begin
               rsp_in.action = ihcf_pkg::ACT_TIME_EXCEEDED;
               rsp_in.reply_length = s2_ff.quote_len;
            end else begin
               rsp_in.action = ihcf_pkg::ACT_SILENT_DROP;
            end
         end else begin
            rsp_in.action = ihcf_pkg::ACT_FORWARD;
            rsp_in.new_ttl = s2_ff.next_ttl;
            rsp_in.new_header_checksum = ~ihcf_pkg::fold16(s2_ff.fwd_sum);
         end
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         rsp_ff <= rsp_in;
      end
   end

   `ASSERT_IMPLY(a_malformed_clean, clock, reset, rsp_valid_ff && rsp_ff.action == ihcf_pkg::ACT_MALFORMED, rsp_ff.reply_target == 32'd0 && rsp_ff.new_ttl == 8'd0 && rsp_ff.new_header_checksum == 16'd0)
   `ASSERT_IMPLY(a_forward_ttl, clock, reset, rsp_valid_ff && rsp_ff.action == ihcf_pkg::ACT_FORWARD, rsp_ff.new_ttl != 8'd0 && rsp_ff.new_ttl != ihcf_pkg::TTL_MAX)
   `ASSERT_IMPLY(a_quote_only_icmp_err, clock, reset, rsp_valid_ff && rsp_ff.reply_length != 7'd0, rsp_ff.action == ihcf_pkg::ACT_TIME_EXCEEDED || rsp_ff.action == ihcf_pkg::ACT_PROTO_UNREACH)

endmodule

// ===== design/ipv4_header_check_and_forward.sv =====
`timescale 1ns / 1ps
// IPv4 header check and forwarding verdict. Packet bytes enter one per clock
// on the request channel, last_byte marking the end of a packet; each packet
// yields exactly one verdict on the response channel and no other byte does.
// The front captures header fields and the header word sum as bytes arrive,
// so input runs at one byte per cycle back to back, across packet bounds.
// Captured headers wait in a two-entry queue; the back checks them and forms
// the verdict in three registered stages behind the queue. The input
// stalls only when two finished headers are queued behind a held response.
// Write own_address (index 0) and point_to_point (index 1) while idle; both
// reset to zero.
module ipv4_header_check_and_forward (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ihcf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ihcf_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);

   logic [31:0]       own_address_ff;
   logic              point_to_point_ff;
   logic              q_full, q_push, q_pop, q_valid;
   ihcf_pkg::pkt_type q_wdata, q_rdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff    <= 32'd0;
         point_to_point_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            ihcf_pkg::CSR_OWN_ADDRESS:    own_address_ff    <= csr_wdata;
            ihcf_pkg::CSR_POINT_TO_POINT: point_to_point_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   ihcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   ihcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_rdata)
   );

   ihcf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_data         (q_rdata),
      .q_pop          (q_pop),
      .own_address    (own_address_ff),
      .point_to_point (point_to_point_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule
